[hdl/csm_pkg.sv]
// Package for the CSS byte stream minifier: mode and held-byte codes,
// character constants and the output queue entry type. No dependencies.
package csm_pkg;

	typedef enum logic [1:0] {
		MODE_TEXT    = 2'd0,
		MODE_BRACE   = 2'd1,
		MODE_COMMENT = 2'd2,
		MODE_QUOTE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_SLASH = 2'd1,
		HOLD_STAR  = 2'd2,
		HOLD_BSL   = 2'd3
	} hold_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// one queued output byte and its end-of-item mark
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} outq_t;

endpackage

[hdl/css_byte_stream_minifier_core.sv]
// CSS byte stream minifier, top level: input register, per-byte scanner
// and a two-entry output queue. Depends on csm_pkg.
//
// Each byte's output passes the input register, then the output queue registers.
// Throughput: one input byte per cycle while each yields at most one output
// and m_tready is high; an item yielding two bytes fills both queue entries.
// Reset (arst_n low, asynchronous): text mode, nothing held, queue empty.
module css_byte_stream_minifier_core
	import csm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // last
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	mode_t      mode_q, mode_n;
	hold_t      hold_q, hold_n;
	logic       rtb_q, rtb_n;
	logic [7:0] quote_q, quote_n;
	logic [7:0] last_out_q, last_out_n;

	outq_t      ob_q [2];
	outq_t      ob_n [2];
	logic [1:0] cnt_q, cnt_p, cnt_n;

	logic [1:0] n_out;
	logic [7:0] r0, r1;
	logic       pop, adv;
	logic [2:0] fill;
	mode_t      resume;

	assign resume = rtb_q ? MODE_BRACE : MODE_TEXT;

	// scanner: results and next state for the byte in the input register
	always_comb begin
		mode_n     = mode_q;
		hold_n     = HOLD_NONE;
		rtb_n      = rtb_q;
		quote_n    = quote_q;
		n_out      = 2'd0;
		r0         = byte_s1;
		r1         = byte_s1;
		if (hold_q == HOLD_SLASH) begin
			if (byte_s1 == CH_STAR) begin
				rtb_n  = (mode_q == MODE_BRACE);
				mode_n = MODE_COMMENT;
			end else begin
				r0    = CH_SLASH;
				n_out = 2'd2;
			end
		end else if (hold_q == HOLD_BSL) begin
			r0    = CH_BSL;
			n_out = 2'd2;
		end else if (hold_q == HOLD_STAR && byte_s1 == CH_SLASH) begin
			mode_n = resume;
		end else begin
			case (mode_q)
				MODE_COMMENT: begin
					if (byte_s1 == CH_STAR)
						hold_n = HOLD_STAR;
				end
				MODE_QUOTE: begin
					if (byte_s1 == CH_BSL) begin
						hold_n = HOLD_BSL;
					end else begin
						n_out = 2'd1;
						if (byte_s1 == quote_q)
							mode_n = resume;
					end
				end
				MODE_TEXT: begin
					if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB) begin
						if (last_out_q != CH_SPACE && last_out_q != CH_TAB)
							n_out = 2'd1;
					end else if (byte_s1 == CH_SLASH) begin
						hold_n = HOLD_SLASH;
					end else if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
						quote_n = byte_s1;
						n_out   = 2'd1;
						rtb_n   = 1'b0;
						mode_n  = MODE_QUOTE;
					end else if (byte_s1 == CH_LBRACE) begin
						n_out  = 2'd1;
						mode_n = MODE_BRACE;
					end else if (byte_s1 != CH_LF && byte_s1 != CH_CR) begin
						n_out = 2'd1;
					end
				end
				default: begin // brace block
					if (byte_s1 == CH_RBRACE) begin
						n_out  = 2'd1;
						mode_n = MODE_TEXT;
					end else if ((byte_s1 == CH_SPACE && last_out_q == CH_SPACE) ||
						byte_s1 == CH_LF || byte_s1 == CH_CR || byte_s1 == CH_TAB) begin
						n_out = 2'd0;
					end else if (byte_s1 == CH_SLASH) begin
						hold_n = HOLD_SLASH;
					end else if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
						quote_n = byte_s1;
						n_out   = 2'd1;
						rtb_n   = 1'b1;
						mode_n  = MODE_QUOTE;
					end else begin
						n_out = 2'd1;
					end
				end
			endcase
		end
		last_out_n = (n_out != 2'd0) ? byte_s1 : last_out_q;
	end

	// output queue: pop the head, then append this item's bytes if they fit
	assign pop  = (cnt_q != 2'd0) && m_tready;
	assign fill = {1'b0, cnt_p} + {1'b0, n_out};
	assign adv  = valid_s1 && (fill <= 3'd2);

	always_comb begin
		ob_n[0] = ob_q[0];
		ob_n[1] = ob_q[1];
		cnt_p   = cnt_q;
		if (pop) begin
			ob_n[0] = ob_q[1];
			cnt_p   = cnt_q - 2'd1;
		end
		cnt_n = cnt_p;
		if (adv) begin
			cnt_n = fill[1:0];
			if (n_out != 2'd0)
				ob_n[cnt_p[0]] = '{data: r0, last: (n_out == 2'd1)};
			if (n_out == 2'd2)
				ob_n[1] = '{data: r1, last: 1'b1};
		end
	end

	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = ob_q[0].data;
	assign m_tlast  = ob_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			cnt_q      <= 2'd0;
			mode_q     <= MODE_TEXT;
			hold_q     <= HOLD_NONE;
			rtb_q      <= 1'b0;
			quote_q    <= 8'h00;
			last_out_q <= 8'h00;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			cnt_q <= cnt_n;
			if (adv) begin
				mode_q     <= mode_n;
				hold_q     <= hold_n;
				rtb_q      <= rtb_n;
				quote_q    <= quote_n;
				last_out_q <= last_out_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
		ob_q[0] <= ob_n[0];
		ob_q[1] <= ob_n[1];
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_bsl_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q == HOLD_BSL |-> mode_q == MODE_QUOTE)
		else $error("held backslash outside a string");

	a_star_in_comment: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q == HOLD_STAR |-> mode_q == MODE_COMMENT)
		else $error("held star outside a comment");

	a_slash_mode: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q == HOLD_SLASH |-> (mode_q == MODE_TEXT || mode_q == MODE_BRACE))
		else $error("held slash in comment or string");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");
`endif

endmodule
